>>> hdl/bret_pkg.sv
// Package for the basic regular expression tokenizer: state and token types,
// mode and token codes, and the per-pass lexer functions.
// No dependencies.
package bret_pkg;

  localparam int POS_W  = 16;
  localparam int GRP_W  = 8;
  localparam int MAX_TOK = 4;
  localparam int CNT_W  = $clog2(MAX_TOK + 1);

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [GRP_W-1:0] grp_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [3:0] {
    M_START, M_TOP, M_DOLLAR, M_COUNT, M_BR_OPEN, M_BR_CARET, M_BR_BODY,
    M_BR_MINUS, M_BR_LBR, M_COLL_DOT, M_COLL_EQ, M_COLL_COLON, M_DRAIN
  } mode_t;

  typedef enum logic [4:0] {
    K_LANCHOR, K_QUOTED, K_LSB, K_CARET, K_COLL1, K_MINUS, K_LSB_DOT, K_COLLN,
    K_META, K_DOT_RSB, K_LSB_EQ, K_EQ_RSB, K_LSB_COLON, K_CLASS, K_COLON_RSB,
    K_RSB, K_PERIOD, K_BS_LPAREN, K_ORD, K_STAR, K_RANCHOR, K_DUPCOUNT,
    K_COMMA, K_BACKREF, K_BS_LCURLY, K_BS_RPAREN, K_BS_RCURLY
  } kind_t;

  typedef enum logic [1:0] {
    E_NONE, E_BRACKET, E_BACKREF, E_ESCAPE
  } err_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOLL  = 8'h24;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LCUR  = 8'h7B;
  localparam logic [7:0] CH_RCUR  = 8'h7D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    mode_t      mode;
    logic       esc;
    kind_t      prev;
    logic       have_prev;
    pos_t       pos;
    pos_t       sot;
    grp_t       grp;
    logic [7:0] held;
    logic [7:0] last_byte;
  } lex_state_t;

  typedef struct packed {
    kind_t kind;
    pos_t  off;
    pos_t  len;
    grp_t  grp;
    err_t  err;
    logic  done;
  } tok_t;

  typedef struct packed {
    lex_state_t        st;
    tok_t [MAX_TOK-1:0] res;
    cnt_t              cnt;
    logic              again;
  } lex_work_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic lex_state_t fresh_state();
    lex_state_t s;
    s = '0;
    s.mode = M_START;
    s.prev = K_LANCHOR;
    return s;
  endfunction

  function automatic lex_work_t put(lex_work_t w, kind_t kind, pos_t off, pos_t len,
                                    grp_t grp, err_t err, logic done);
    if (w.cnt < cnt_t'(MAX_TOK)) begin
      w.res[w.cnt[CNT_W-2:0]] = '{kind: kind, off: off, len: len, grp: grp,
                                   err: err, done: done};
      w.cnt = w.cnt + cnt_t'(1);
    end
    return w;
  endfunction

  function automatic lex_work_t consume(lex_work_t w, logic [7:0] c);
    w.st.last_byte = c;
    w.st.pos = w.st.pos + pos_t'(1);
    return w;
  endfunction

  function automatic lex_work_t commit(lex_work_t w, kind_t kind, grp_t grp);
    w = put(w, kind, w.st.sot, w.st.pos - w.st.sot, grp, E_NONE, 1'b0);
    w.st.sot = w.st.pos;
    w.st.prev = kind;
    w.st.have_prev = 1'b1;
    return w;
  endfunction

  function automatic lex_work_t finish(lex_work_t w, err_t err, logic [7:0] c);
    w = put(w, K_LANCHOR, w.st.pos, '0, '0, err, 1'b1);
    if (c == CH_NUL) w.st = fresh_state();
    else w.st.mode = M_DRAIN;
    return w;
  endfunction

  function automatic lex_work_t top_byte(lex_work_t w, logic [7:0] c, logic nosub);
    logic esc;
    esc = w.st.esc;
    w.st.esc = 1'b0;
    if (c == CH_NUL) return finish(w, esc ? E_ESCAPE : E_NONE, c);
    w = consume(w, c);
    if (c == CH_BSL) begin
      if (esc) w = commit(w, K_QUOTED, '0);
      else w.st.esc = 1'b1;
      return w;
    end
    if (esc && !(c == CH_COMMA || is_digit(c) || c == CH_LPAR || c == CH_RPAR ||
                 c == CH_LCUR || c == CH_RCUR))
      return commit(w, K_QUOTED, '0);
    if (is_digit(c)) begin
      if (esc) begin
        if (c == CH_ZERO || nosub) w = finish(w, E_BACKREF, c);
        else w = commit(w, K_BACKREF, '0);
      end else if (w.st.have_prev &&
                   (w.st.prev == K_BS_LCURLY || w.st.prev == K_COMMA)) begin
        w.st.mode = M_COUNT;
      end else begin
        w = commit(w, K_ORD, '0);
      end
      return w;
    end
    case (c)
      CH_LBR: begin
        w = commit(w, K_LSB, '0);
        w.st.mode = M_BR_OPEN;
      end
      CH_DOT: w = commit(w, K_PERIOD, '0);
      CH_STAR: begin
        if (!w.st.have_prev || w.st.prev == K_LANCHOR || w.st.prev == K_BS_LPAREN)
          w = commit(w, K_ORD, '0);
        else
          w = commit(w, K_STAR, '0);
      end
      CH_DOLL: w.st.mode = M_DOLLAR;
      CH_COMMA: begin
        w = commit(w, (w.st.have_prev && w.st.prev == K_DUPCOUNT) ? K_COMMA : K_ORD,
                   '0);
      end
      CH_LPAR: begin
        if (esc) begin
          w.st.grp = w.st.grp + grp_t'(1);
          w = commit(w, K_BS_LPAREN, w.st.grp);
        end else begin
          w = commit(w, K_ORD, '0);
        end
      end
      CH_RPAR: w = commit(w, esc ? K_BS_RPAREN : K_ORD, '0);
      CH_LCUR: w = commit(w, esc ? K_BS_LCURLY : K_ORD, '0);
      CH_RCUR: w = commit(w, esc ? K_BS_RCURLY : K_ORD, '0);
      default: w = commit(w, K_ORD, '0);
    endcase
    return w;
  endfunction

  function automatic lex_work_t coll_byte(lex_work_t w, logic [7:0] c);
    logic [7:0] d;
    kind_t body;
    kind_t close;
    d = (w.st.mode == M_COLL_DOT) ? CH_DOT : ((w.st.mode == M_COLL_EQ) ? CH_EQ : CH_COLON);
    if (w.st.held != CH_NUL) begin
      if (c == CH_RBR) begin
        // closer found: emit body, then the two-byte closer
        if (d == CH_DOT) begin
          if ((w.st.pos - w.st.sot) > pos_t'(1)) body = K_COLLN;
          else if (w.st.last_byte == CH_MINUS || w.st.last_byte == CH_RBR) body = K_META;
          else body = K_COLL1;
          close = K_DOT_RSB;
        end else if (d == CH_EQ) begin
          body = ((w.st.pos - w.st.sot) > pos_t'(1)) ? K_COLLN : K_COLL1;
          close = K_EQ_RSB;
        end else begin
          body = K_CLASS;
          close = K_COLON_RSB;
        end
        w = commit(w, body, '0);
        w = consume(w, w.st.held);
        w.st.held = CH_NUL;
        w = consume(w, c);
        w = commit(w, close, '0);
        w.st.mode = M_BR_BODY;
        return w;
      end
      w = consume(w, w.st.held);
      w.st.held = CH_NUL;
    end
    if (c == CH_NUL) w = finish(w, E_BRACKET, c);
    else if (c == d) w.st.held = c;
    else w = consume(w, c);
    return w;
  endfunction

  // One pass of the lexer; sets again when the byte must be looked at once more
  function automatic lex_work_t lex_pass(lex_work_t w, logic [7:0] c, logic nosub);
    w.again = 1'b0;
    case (w.st.mode)
      M_START: begin
        w.st.mode = M_TOP;
        if (c == CH_CARET) begin
          w = consume(w, c);
          w = commit(w, K_LANCHOR, '0);
        end else begin
          w.again = 1'b1;
        end
      end
      M_TOP: w = top_byte(w, c, nosub);
      M_DOLLAR: begin
        w = commit(w, (c == CH_NUL) ? K_RANCHOR : K_ORD, '0);
        w.st.mode = M_TOP;
        w.again = 1'b1;
      end
      M_COUNT: begin
        if (is_digit(c)) begin
          w = consume(w, c);
        end else begin
          w = commit(w, K_DUPCOUNT, '0);
          w.st.mode = M_TOP;
          w.again = 1'b1;
        end
      end
      M_BR_OPEN: begin
        w.st.mode = M_BR_CARET;
        if (c == CH_CARET) begin
          w = consume(w, c);
          w = commit(w, K_CARET, '0);
        end else begin
          w.again = 1'b1;
        end
      end
      M_BR_CARET: begin
        w.st.mode = M_BR_BODY;
        if (c == CH_RBR || c == CH_MINUS) begin
          w = consume(w, c);
          w = commit(w, K_COLL1, '0);
        end else begin
          w.again = 1'b1;
        end
      end
      M_BR_BODY: begin
        if (c == CH_NUL) begin
          w = finish(w, E_BRACKET, c);
        end else if (c == CH_RBR) begin
          w = consume(w, c);
          w = commit(w, K_RSB, '0);
          w.st.mode = M_TOP;
        end else if (c == CH_MINUS) begin
          w = consume(w, c);
          w.st.mode = M_BR_MINUS;
        end else if (c == CH_LBR) begin
          w = consume(w, c);
          w.st.mode = M_BR_LBR;
        end else begin
          w = consume(w, c);
          w = commit(w, K_COLL1, '0);
        end
      end
      M_BR_MINUS: begin
        w = commit(w, (c == CH_RBR || (w.st.have_prev && w.st.prev == K_MINUS)) ?
                   K_COLL1 : K_MINUS, '0);
        w.st.mode = M_BR_BODY;
        w.again = 1'b1;
      end
      M_BR_LBR: begin
        if (c == CH_DOT) begin
          w = consume(w, c);
          w = commit(w, K_LSB_DOT, '0);
          w.st.mode = M_COLL_DOT;
        end else if (c == CH_EQ) begin
          w = consume(w, c);
          w = commit(w, K_LSB_EQ, '0);
          w.st.mode = M_COLL_EQ;
        end else if (c == CH_COLON) begin
          w = consume(w, c);
          w = commit(w, K_LSB_COLON, '0);
          w.st.mode = M_COLL_COLON;
        end else begin
          w = commit(w, K_COLL1, '0);
          w.st.mode = M_BR_BODY;
          w.again = 1'b1;
        end
      end
      M_COLL_DOT, M_COLL_EQ, M_COLL_COLON: w = coll_byte(w, c);
      default: begin
        if (c == CH_NUL) w.st = fresh_state();
      end
    endcase
    return w;
  endfunction

endpackage

>>> hdl/bret_step.sv
// Combinational lexer step: one pattern byte against the lexer state.
// Depends on bret_pkg (types and pass functions).
module bret_step (
  input  bret_pkg::lex_state_t               st,
  input  logic [7:0]                         pattern_byte,
  input  logic                               nosub,
  output bret_pkg::lex_state_t               st_nxt,
  output bret_pkg::tok_t [bret_pkg::MAX_TOK-1:0] toks,
  output bret_pkg::cnt_t                     tok_cnt
);
  import bret_pkg::*;

  lex_work_t w;

  // Run up to three passes: bracket open, caret check, body is the longest chain
  always_comb begin
    w = '0;
    w.st = st;
    w = lex_pass(w, pattern_byte, nosub);
    if (w.again) w = lex_pass(w, pattern_byte, nosub);
    if (w.again) w = lex_pass(w, pattern_byte, nosub);
  end

  assign st_nxt  = w.st;
  assign toks    = w.res;
  assign tok_cnt = w.cnt;

endmodule

>>> hdl/bret_batch.sv
// Result buffer: holds one byte's tokens, sends one beat a cycle when not stalled.
// Depends on bret_pkg (token type and count width).
module bret_batch (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  bret_pkg::tok_t [bret_pkg::MAX_TOK-1:0] toks,
  input  bret_pkg::cnt_t                     tok_cnt,
  output logic                               free,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bret_pkg::tok_t                     out_tok,
  output logic                               out_last
);
  import bret_pkg::*;

  localparam int IDX_W = CNT_W - 1;

  tok_t [MAX_TOK-1:0] tok_r;
  cnt_t               cnt_r;
  logic [IDX_W-1:0]   idx_r;
  logic               take;

  assign out_valid = (cnt_r != '0);
  assign out_tok   = tok_r[idx_r];
  assign out_last  = ({1'b0, idx_r} == (cnt_r - cnt_t'(1)));
  assign take      = out_valid && !out_stall;
  assign free      = !out_valid || (take && out_last);

  // Hold the token payload of the current byte
  always_ff @(posedge clk) begin
    if (load && free) tok_r <= toks;
  end

  // Advance through the batch, reload when drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load && free) begin
      cnt_r <= tok_cnt;
      idx_r <= '0;
    end else if (take) begin
      if (out_last) cnt_r <= '0;
      else idx_r <= idx_r + IDX_W'(1);
    end
  end

endmodule

>>> hdl/posix_bre_tokenizer_top.sv
// Top level of the basic regular expression tokenizer.
// Depends on bret_pkg, bret_step and bret_batch.
//
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_stall   in_pattern_byte
//  out_     output     out_valid/out_stall token kind, offset, length, group, error, flags
//  cfg_     input      cfg_wr_en           cfg_wr_data (no_subexpressions)
//
// One byte a cycle enters an input register while in_stall is low; the lexer step
// between that register and the result buffer is combinational.
// While out_stall is low, the result buffer drains one beat a cycle: a byte with more
// than one token (up to four) stalls the input, bytes with zero or one go back to back.
// Reset is synchronous and clears the lexer state and the no_subexpressions bit.
// out_stall holds the result buffer and, once it is full, the input register.
module posix_bre_tokenizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pattern_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_token_offset,
  output logic [15:0] out_token_length,
  output logic [7:0]  out_group_number,
  output logic [1:0]  out_error_kind,
  output logic        out_pattern_done,
  output logic        out_last_of_run,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);
  import bret_pkg::*;

  logic               in_vld_r;
  logic [7:0]         in_byte_r;
  logic               nosub_r;
  lex_state_t         st_r;
  lex_state_t         st_nxt;
  tok_t [MAX_TOK-1:0] toks;
  cnt_t               tok_cnt;
  logic               free;
  logic               step_take;
  tok_t               out_tok;

  assign step_take = in_vld_r && free;
  assign in_stall  = in_vld_r && !free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) in_byte_r <= in_pattern_byte;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) nosub_r <= 1'b0;
    else if (cfg_wr_en) nosub_r <= cfg_wr_data;
  end

  // Lexer state, advanced once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= fresh_state();
    else if (step_take) st_r <= st_nxt;
  end

  bret_step u_step (
    .st           (st_r),
    .pattern_byte (in_byte_r),
    .nosub        (nosub_r),
    .st_nxt       (st_nxt),
    .toks         (toks),
    .tok_cnt      (tok_cnt)
  );

  bret_batch u_batch (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_vld_r),
    .toks      (toks),
    .tok_cnt   (tok_cnt),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_tok   (out_tok),
    .out_last  (out_last_of_run)
  );

  assign out_token_kind   = out_tok.kind;
  assign out_token_offset = out_tok.off;
  assign out_token_length = out_tok.len;
  assign out_group_number = out_tok.grp;
  assign out_error_kind   = out_tok.err;
  assign out_pattern_done = out_tok.done;

`ifndef SYNTHESIS
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with no byte held");
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pattern_done) |-> out_last_of_run)
    else $error("end marker not last beat of its byte");
  a_err_on_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_kind != E_NONE) |-> out_pattern_done)
    else $error("error reported on a plain token");
  a_group_on_paren: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_group_number != '0) |-> (out_token_kind == K_BS_LPAREN))
    else $error("group number on a non-group token");
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step_take |=> (st_r == $past(st_r)))
    else $error("lexer state moved without a byte");
`endif

endmodule

>>> bench/posix_bre_tokenizer_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for posix_bre_tokenizer_top: drives pattern bytes, predicts the token
// beats with an in-bench lexer and compares each result beat field by field.
// Depends on bret_pkg and the tokenizer RTL.
module posix_bre_tokenizer_top_test;
  import bret_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    kind_t      kind;
    logic [15:0] off;
    logic [15:0] len;
    logic [7:0]  grp;
    err_t       err;
    logic       done;
    logic       last;
  } token_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_pattern_byte;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  out_token_kind;
  logic [15:0] out_token_offset;
  logic [15:0] out_token_length;
  logic [7:0]  out_group_number;
  logic [1:0]  out_error_kind;
  logic        out_pattern_done;
  logic        out_last_of_run;
  logic        cfg_wr_en;
  logic        cfg_wr_data;

  logic [7:0]  pattern_q[$];
  token_beat_t token_q[$];
  int          mismatches;
  int          cycles;
  int          send_gap;
  int          stall_left;
  bit          quiet;

  // lexer mirror
  mode_t       lex_mode;
  logic        lex_esc;
  kind_t       lex_prev;
  logic        lex_have_prev;
  logic [15:0] lex_pos;
  logic [15:0] lex_sot;
  logic [7:0]  lex_groups;
  logic [7:0]  lex_held;
  logic [7:0]  lex_last;
  logic        nosub_cfg;
  int          step_count;

  posix_bre_tokenizer_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_pattern_byte(in_pattern_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_token_kind(out_token_kind), .out_token_offset(out_token_offset),
    .out_token_length(out_token_length), .out_group_number(out_group_number),
    .out_error_kind(out_error_kind), .out_pattern_done(out_pattern_done),
    .out_last_of_run(out_last_of_run),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic bit numeral(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (quiet || r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic restart_lexer();
    lex_mode = M_START;
    lex_esc = 1'b0;
    lex_prev = K_LANCHOR;
    lex_have_prev = 1'b0;
    lex_pos = '0;
    lex_sot = '0;
    lex_groups = '0;
    lex_held = '0;
    lex_last = '0;
  endtask

  task automatic emit(kind_t kind, logic [15:0] off, logic [15:0] len, logic [7:0] grp,
                      err_t err, logic done);
    token_beat_t t;
    if (step_count < 4) begin
      t = '{kind: kind, off: off, len: len, grp: grp, err: err, done: done, last: 1'b0};
      token_q.push_back(t);
      step_count++;
    end
  endtask

  task automatic take(logic [7:0] c);
    lex_last = c;
    lex_pos = lex_pos + 16'd1;
  endtask

  task automatic accept_token(kind_t kind, logic [7:0] grp);
    emit(kind, lex_sot, lex_pos - lex_sot, grp, E_NONE, 1'b0);
    lex_sot = lex_pos;
    lex_prev = kind;
    lex_have_prev = 1'b1;
  endtask

  task automatic close_pattern(err_t err, logic [7:0] c);
    emit(K_LANCHOR, lex_pos, '0, '0, err, 1'b1);
    if (c == CH_NUL) restart_lexer();
    else lex_mode = M_DRAIN;
  endtask

  task automatic top_level(logic [7:0] c);
    logic was_esc;
    was_esc = lex_esc;
    lex_esc = 1'b0;
    if (c == CH_NUL) begin
      close_pattern(was_esc ? E_ESCAPE : E_NONE, c);
      return;
    end
    take(c);
    if (c == CH_BSL) begin
      if (was_esc) accept_token(K_QUOTED, '0);
      else lex_esc = 1'b1;
      return;
    end
    if (was_esc && !(c == CH_COMMA || numeral(c) || c == CH_LPAR || c == CH_RPAR ||
                     c == CH_LCUR || c == CH_RCUR)) begin
      accept_token(K_QUOTED, '0);
      return;
    end
    if (numeral(c)) begin
      if (was_esc) begin
        if (c == CH_ZERO || nosub_cfg) close_pattern(E_BACKREF, c);
        else accept_token(K_BACKREF, '0);
      end else if (lex_have_prev && (lex_prev == K_BS_LCURLY || lex_prev == K_COMMA)) begin
        lex_mode = M_COUNT;
      end else begin
        accept_token(K_ORD, '0);
      end
      return;
    end
    case (c)
      CH_LBR: begin
        accept_token(K_LSB, '0);
        lex_mode = M_BR_OPEN;
      end
      CH_DOT: accept_token(K_PERIOD, '0);
      CH_STAR: begin
        if (!lex_have_prev || lex_prev == K_LANCHOR || lex_prev == K_BS_LPAREN)
          accept_token(K_ORD, '0);
        else
          accept_token(K_STAR, '0);
      end
      CH_DOLL: lex_mode = M_DOLLAR;
      CH_COMMA: accept_token((lex_have_prev && lex_prev == K_DUPCOUNT) ? K_COMMA : K_ORD, '0);
      CH_LPAR: begin
        if (was_esc) begin
          lex_groups = lex_groups + 8'd1;
          accept_token(K_BS_LPAREN, lex_groups);
        end else begin
          accept_token(K_ORD, '0);
        end
      end
      CH_RPAR: accept_token(was_esc ? K_BS_RPAREN : K_ORD, '0);
      CH_LCUR: accept_token(was_esc ? K_BS_LCURLY : K_ORD, '0);
      CH_RCUR: accept_token(was_esc ? K_BS_RCURLY : K_ORD, '0);
      default: accept_token(K_ORD, '0);
    endcase
  endtask

  // Collating, equivalence and class bodies: hold the delimiter until ']' decides
  task automatic element_body(logic [7:0] c);
    logic [7:0] delim;
    kind_t      body;
    kind_t      closer;
    delim = (lex_mode == M_COLL_DOT) ? CH_DOT : ((lex_mode == M_COLL_EQ) ? CH_EQ : CH_COLON);
    if (lex_held != CH_NUL) begin
      if (c == CH_RBR) begin
        if (delim == CH_DOT) begin
          if (lex_pos - lex_sot > 16'd1) body = K_COLLN;
          else if (lex_last == CH_MINUS || lex_last == CH_RBR) body = K_META;
          else body = K_COLL1;
          closer = K_DOT_RSB;
        end else if (delim == CH_EQ) begin
          body = (lex_pos - lex_sot > 16'd1) ? K_COLLN : K_COLL1;
          closer = K_EQ_RSB;
        end else begin
          body = K_CLASS;
          closer = K_COLON_RSB;
        end
        accept_token(body, '0);
        take(lex_held);
        lex_held = CH_NUL;
        take(c);
        accept_token(closer, '0);
        lex_mode = M_BR_BODY;
        return;
      end
      take(lex_held);
      lex_held = CH_NUL;
    end
    if (c == CH_NUL) close_pattern(E_BRACKET, c);
    else if (c == delim) lex_held = c;
    else take(c);
  endtask

  // Work out every token beat that one pattern byte releases
  task automatic predict_tokens(logic [7:0] c);
    bit again;
    step_count = 0;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (lex_mode)
        M_START: begin
          lex_mode = M_TOP;
          if (c == CH_CARET) begin
            take(c);
            accept_token(K_LANCHOR, '0);
          end else again = 1'b1;
        end
        M_TOP: top_level(c);
        M_DOLLAR: begin
          accept_token(c == CH_NUL ? K_RANCHOR : K_ORD, '0);
          lex_mode = M_TOP;
          again = 1'b1;
        end
        M_COUNT: begin
          if (numeral(c)) take(c);
          else begin
            accept_token(K_DUPCOUNT, '0);
            lex_mode = M_TOP;
            again = 1'b1;
          end
        end
        M_BR_OPEN: begin
          lex_mode = M_BR_CARET;
          if (c == CH_CARET) begin
            take(c);
            accept_token(K_CARET, '0);
          end else again = 1'b1;
        end
        M_BR_CARET: begin
          lex_mode = M_BR_BODY;
          if (c == CH_RBR || c == CH_MINUS) begin
            take(c);
            accept_token(K_COLL1, '0);
          end else again = 1'b1;
        end
        M_BR_BODY: begin
          if (c == CH_NUL) close_pattern(E_BRACKET, c);
          else if (c == CH_RBR) begin
            take(c);
            accept_token(K_RSB, '0);
            lex_mode = M_TOP;
          end else if (c == CH_MINUS) begin
            take(c);
            lex_mode = M_BR_MINUS;
          end else if (c == CH_LBR) begin
            take(c);
            lex_mode = M_BR_LBR;
          end else begin
            take(c);
            accept_token(K_COLL1, '0);
          end
        end
        M_BR_MINUS: begin
          accept_token((c == CH_RBR || (lex_have_prev && lex_prev == K_MINUS)) ?
                       K_COLL1 : K_MINUS, '0);
          lex_mode = M_BR_BODY;
          again = 1'b1;
        end
        M_BR_LBR: begin
          if (c == CH_DOT) begin
            take(c);
            accept_token(K_LSB_DOT, '0);
            lex_mode = M_COLL_DOT;
          end else if (c == CH_EQ) begin
            take(c);
            accept_token(K_LSB_EQ, '0);
            lex_mode = M_COLL_EQ;
          end else if (c == CH_COLON) begin
            take(c);
            accept_token(K_LSB_COLON, '0);
            lex_mode = M_COLL_COLON;
          end else begin
            accept_token(K_COLL1, '0);
            lex_mode = M_BR_BODY;
            again = 1'b1;
          end
        end
        M_COLL_DOT, M_COLL_EQ, M_COLL_COLON: element_body(c);
        default: if (c == CH_NUL) restart_lexer();
      endcase
    end
    if (step_count > 0) token_q[token_q.size() - 1].last = 1'b1;
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  // Driver: advance to the next byte once the current beat is taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_tokens(in_pattern_byte);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0 || pattern_q.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_pattern_byte <= pattern_q.pop_front();
          send_gap = pick_gap();
        end
      end
    end
  end

  // Result side: random stall runs
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      out_stall <= (stall_left > 0);
    end
  end

  // Monitor: check each accepted result beat against the oldest prediction
  always @(posedge clk) begin
    token_beat_t t;
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        report("unexpected beat, kind", out_token_kind, -1);
      end else begin
        t = token_q.pop_front();
        if (out_token_kind !== t.kind) report("token_kind", out_token_kind, t.kind);
        if (out_token_offset !== t.off) report("token_offset", out_token_offset, t.off);
        if (out_token_length !== t.len) report("token_length", out_token_length, t.len);
        if (out_group_number !== t.grp) report("group_number", out_group_number, t.grp);
        if (out_error_kind !== t.err) report("error_kind", out_error_kind, t.err);
        if (out_pattern_done !== t.done) report("pattern_done", out_pattern_done, t.done);
        if (out_last_of_run !== t.last) report("last_of_run", out_last_of_run, t.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) pattern_q.push_back(s[i]);
    pattern_q.push_back(CH_NUL);
  endtask

  task automatic push_digits();
    repeat ($urandom_range(1, 3)) pattern_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic push_letters();
    repeat ($urandom_range(1, 3)) pattern_q.push_back(8'("a" + $urandom_range(0, 25)));
  endtask

  // One bracket expression with random members
  task automatic push_bracket();
    pattern_q.push_back(CH_LBR);
    if ($urandom_range(0, 2) == 0) pattern_q.push_back(CH_CARET);
    if ($urandom_range(0, 3) == 0) pattern_q.push_back($urandom_range(0, 1) ? CH_RBR : CH_MINUS);
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 5))
        0: pattern_q.push_back(CH_MINUS);
        1: begin
          pattern_q.push_back(CH_LBR);
          pattern_q.push_back(CH_DOT);
          case ($urandom_range(0, 2))
            0: pattern_q.push_back(CH_MINUS);
            1: pattern_q.push_back(CH_RBR);
            default: push_letters();
          endcase
          if ($urandom_range(0, 3) == 0) pattern_q.push_back(CH_DOT);
          pattern_q.push_back(CH_DOT);
          pattern_q.push_back(CH_RBR);
        end
        2: begin
          pattern_q.push_back(CH_LBR);
          pattern_q.push_back(CH_EQ);
          push_letters();
          pattern_q.push_back(CH_EQ);
          pattern_q.push_back(CH_RBR);
        end
        3: begin
          pattern_q.push_back(CH_LBR);
          pattern_q.push_back(CH_COLON);
          push_letters();
          pattern_q.push_back(CH_COLON);
          pattern_q.push_back(CH_RBR);
        end
        4: pattern_q.push_back(CH_LBR);
        default: push_letters();
      endcase
    end
    if ($urandom_range(0, 9) != 0) pattern_q.push_back(CH_RBR);
  endtask

  // A well-formed-ish pattern with random content, or now and then raw noise
  task automatic push_random_pattern();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) pattern_q.push_back(8'($urandom_range(0, 255)));
      pattern_q.push_back(CH_NUL);
      return;
    end
    if ($urandom_range(0, 2) == 0) pattern_q.push_back(CH_CARET);
    repeat ($urandom_range(1, 7)) begin
      case ($urandom_range(0, 11))
        0: push_letters();
        1: pattern_q.push_back(8'($urandom_range(1, 255)));
        2: begin
          pattern_q.push_back(CH_BSL);
          pattern_q.push_back(CH_LPAR);
        end
        3: begin
          pattern_q.push_back(CH_BSL);
          pattern_q.push_back(CH_RPAR);
        end
        4: begin
          pattern_q.push_back(CH_BSL);
          pattern_q.push_back(CH_LCUR);
          push_digits();
          if ($urandom_range(0, 1)) begin
            pattern_q.push_back(CH_COMMA);
            if ($urandom_range(0, 1)) push_digits();
          end
          pattern_q.push_back(CH_BSL);
          pattern_q.push_back(CH_RCUR);
        end
        5: pattern_q.push_back(CH_STAR);
        6: pattern_q.push_back(CH_DOLL);
        7: pattern_q.push_back(CH_DOT);
        8: push_bracket();
        9: begin
          pattern_q.push_back(CH_BSL);
          pattern_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        10: begin
          pattern_q.push_back(CH_BSL);
          pattern_q.push_back(8'($urandom_range(1, 255)));
        end
        default: pattern_q.push_back($urandom_range(0, 1) ? CH_CARET : CH_COMMA);
      endcase
    end
    if ($urandom_range(0, 4) == 0) pattern_q.push_back(CH_BSL);
    pattern_q.push_back(CH_NUL);
  endtask

  // Hold until the sender is dry and every predicted beat has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (pattern_q.size() != 0 || in_valid || token_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_nosub(logic v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    nosub_cfg = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int bytes);
    int target;
    target = pattern_q.size() + bytes;
    while (pattern_q.size() < target) push_random_pattern();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pattern_byte = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    mismatches = 0;
    cycles = 0;
    send_gap = 0;
    stall_left = 0;
    quiet = 1'b1;
    nosub_cfg = 1'b0;
    restart_lexer();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_nosub(1'b0);

    // Directed: anchors, groups, brackets, counts, escapes and all error kinds
    push_text("^a*\\(b\\)\\1$");
    push_text("[^]a-z-][-a--]");
    push_text("[[.-.][.ab.][=e=][:digit:][x]");
    push_text("x\\{2,13\\}*,1");
    push_text("**\\.\\\\$$");
    push_text("\\0zz");
    push_text("ab\\");
    push_text("[ab");
    push_text("[[.a");
    pattern_q.push_back(8'hFF);
    pattern_q.push_back(8'h80);
    pattern_q.push_back(CH_NUL);
    wait_idle();

    quiet = 1'b0;
    random_phase(65);
    wait_idle();
    write_nosub(1'b1);
    push_text("\\(a\\)\\1");
    random_phase(60);
    wait_idle();
    write_nosub(1'b0);
    random_phase(60);
    wait_idle();
    repeat (20) @(posedge clk);

    if (mismatches == 0 && token_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
